### src/rqd_pkg.sv
package rqd_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int HANDLE_BITS_DEFAULT = 16;
   localparam int ID_BITS             = 16;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_GET    = 2'd1,
      OP_FIND   = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2,
      ST_NONE = 2'd3
   } status_type;

   // per-cell control for one cycle
   typedef struct packed {
      logic load;        // capture the key as a new entry
      logic take_upper;  // take the entry of the next cell up
   } cell_ctrl_type;

endpackage

### src/rqd_cell.sv
module rqd_cell #(
   parameter int DEPTH   = rqd_pkg::DEPTH_DEFAULT,
   parameter int HB      = rqd_pkg::HANDLE_BITS_DEFAULT,
   parameter int INDEX   = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rqd_pkg::cell_ctrl_type      ctrl,
   input  logic [$clog2(DEPTH+1)-1:0]  count,
   input  logic [HB-1:0]               key_handle,
   input  logic [rqd_pkg::ID_BITS-1:0] key_id,
   input  logic [HB-1:0]               upper_handle,
   input  logic [rqd_pkg::ID_BITS-1:0] upper_id,
   output logic [HB-1:0]               cell_handle,
   output logic [rqd_pkg::ID_BITS-1:0] cell_id,
   output logic                        handle_match,
   output logic                        id_match
);

   localparam int CW = $clog2(DEPTH+1);

   logic [HB-1:0]               handle_ff, handle_in;
   logic [rqd_pkg::ID_BITS-1:0] id_ff, id_in;
   logic                        hmatch_ff, imatch_ff;
   logic                        occupied;

   assign occupied = count > CW'(INDEX);

   always_comb begin
      handle_in = handle_ff;
      id_in     = id_ff;
      priority if (ctrl.load) begin
         handle_in = key_handle;
         id_in     = key_id;
      end else if (ctrl.take_upper) begin
         handle_in = upper_handle;
         id_in     = upper_id;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      id_ff     <= id_in;
   end

   // compare against the held key every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         hmatch_ff <= 1'b0;
         imatch_ff <= 1'b0;
      end else begin
         hmatch_ff <= occupied && (handle_ff == key_handle);
         imatch_ff <= occupied && (id_ff == key_id);
      end
   end

   assign cell_handle  = handle_ff;
   assign cell_id      = id_ff;
   assign handle_match = hmatch_ff;
   assign id_match     = imatch_ff;

endmodule

### src/ready_queue_with_dedup_remove.sv
// Ordered ready queue of thread entries (handle, thread id), oldest first.
// Request channel req_*: req_tuser carries the operation (put, get oldest,
// find by thread id, remove by handle); req_tdata carries handle and id.
// Response channel rsp_*: one item per request with status in rsp_tuser
// and found handle, found id and the resulting count in rsp_tdata.
// Entries live in a row of cells; each cell compares its entry to the key
// in parallel and registers the match, and on get or remove every cell at
// or above the removed slot takes its upper neighbor's entry in one shift.
// An item takes a compare step in the cells, then a final step to pick the
// result and apply the put or the shift. A new item is taken at the earliest
// in the cycle the last one finishes, if the output register is empty.
// The result sits in an output register; one more item is accepted while
// it waits, and that item holds in its final step until rsp_tready frees
// the register. Reset empties the queue (count zero) and drops any
// pending response; the entry storage itself is not cleared.
module ready_queue_with_dedup_remove #(
   parameter int DEPTH       = rqd_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS = rqd_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // handle[15:0], thread_id[31:16]
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // found_handle[15:0], found_id[31:16],
                                   // count[36:32], zero[39:37]
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam int HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
   localparam int CW = $clog2(DEPTH+1);
   localparam int IB = rqd_pkg::ID_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_DONE
   } state_type;

   state_type    state_ff;
   rqd_pkg::opcode_type op_ff;
   logic [HB-1:0] key_handle_ff;
   logic [IB-1:0] key_id_ff;
   logic [CW-1:0] count_ff, count_in;

   logic         rsp_valid_ff;
   rqd_pkg::status_type status_ff, status_in;
   logic [15:0]  fhandle_ff, fhandle_in;
   logic [15:0]  fid_ff, fid_in;
   logic [4:0]   rcount_ff;

   logic [HB-1:0] cell_handle [DEPTH];
   logic [IB-1:0] cell_id     [DEPTH];
   logic [DEPTH-1:0] hmatch, imatch;
   logic [DEPTH-1:0] last_imatch, sel, at_or_above;
   logic [DEPTH-1:0] rev, rev_low;
   rqd_pkg::cell_ctrl_type ctrl [DEPTH];

   logic accept, finish, shift_en, put_en;
   logic [HB-1:0] pick_handle;
   logic [IB-1:0] pick_id;

   assign req_tready = !reset &&
                       ((state_ff == S_IDLE) || (state_ff == S_DONE && !rsp_valid_ff));
   assign accept     = req_tvalid && req_tready;
   assign finish     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // newest matching id: isolate the highest set bit of imatch
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         rev[i] = imatch[DEPTH-1-i];
      end
      rev_low = rev & (~rev + DEPTH'(1));
      for (int i = 0; i < DEPTH; i++) begin
         last_imatch[i] = rev_low[DEPTH-1-i];
      end
   end

   always_comb begin
      unique case (op_ff)
         rqd_pkg::OP_GET:    sel = (count_ff != '0) ? DEPTH'(1) : '0;
         rqd_pkg::OP_FIND:   sel = last_imatch;
         rqd_pkg::OP_REMOVE: sel = hmatch;
         default: sel = '0;
      endcase
      // slots at or above the selected one; all zeros when nothing is selected
      at_or_above = ~(sel - DEPTH'(1));
   end

   // selected entry through an and-or mux (sel is one-hot or zero)
   always_comb begin
      pick_handle = '0;
      pick_id     = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pick_handle = pick_handle | (cell_handle[i] & {HB{sel[i]}});
         pick_id     = pick_id     | (cell_id[i]     & {IB{sel[i]}});
      end
   end

   always_comb begin
      status_in  = rqd_pkg::ST_NONE;
      fhandle_in = '0;
      fid_in     = '0;
      count_in   = count_ff;
      shift_en   = 1'b0;
      put_en     = 1'b0;
      unique case (op_ff)
         rqd_pkg::OP_PUT: begin
            priority if (|hmatch) begin
               status_in = rqd_pkg::ST_DUP;
            end else if (count_ff == CW'(DEPTH)) begin
               status_in = rqd_pkg::ST_FULL;
            end else begin
               status_in = rqd_pkg::ST_OK;
               put_en    = 1'b1;
               count_in  = count_ff + CW'(1);
            end
         end
         rqd_pkg::OP_GET, rqd_pkg::OP_REMOVE: begin
            if (|sel) begin
               status_in  = rqd_pkg::ST_OK;
               fhandle_in = 16'(pick_handle);
               fid_in     = 16'(pick_id);
               shift_en   = 1'b1;
               count_in   = count_ff - CW'(1);
            end
         end
         rqd_pkg::OP_FIND: begin
            if (|sel) begin
               status_in  = rqd_pkg::ST_OK;
               fhandle_in = 16'(pick_handle);
               fid_in     = 16'(pick_id);
            end
         end
         default: status_in = rqd_pkg::ST_NONE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i].load       = finish && put_en && (count_ff == CW'(i));
         ctrl[i].take_upper = finish && shift_en && at_or_above[i];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [HB-1:0] up_handle;
      logic [IB-1:0] up_id;
      if (g == DEPTH-1) begin : g_top
         assign up_handle = '0;
         assign up_id     = '0;
      end else begin : g_mid
         assign up_handle = cell_handle[g+1];
         assign up_id     = cell_id[g+1];
      end
      rqd_cell #(
         .DEPTH (DEPTH),
         .HB    (HB),
         .INDEX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl[g]),
         .count        (count_ff),
         .key_handle   (key_handle_ff),
         .key_id       (key_id_ff),
         .upper_handle (up_handle),
         .upper_id     (up_id),
         .cell_handle  (cell_handle[g]),
         .cell_id      (cell_id[g]),
         .handle_match (hmatch[g]),
         .id_match     (imatch[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            op_ff         <= rqd_pkg::opcode_type'(req_tuser);
            key_handle_ff <= req_tdata[HB-1:0];
            key_id_ff     <= req_tdata[31:16];
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (finish) begin
                  status_ff    <= status_in;
                  fhandle_ff   <= fhandle_in;
                  fid_ff       <= fid_in;
                  rcount_ff    <= 5'(count_in);
                  count_ff     <= count_in;
                  state_ff     <= accept ? S_CMP : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, rcount_ff, fid_ff, fhandle_ff};

endmodule

### verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = rqd_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 525;

   typedef struct {
      rqd_pkg::status_type status;
      logic [15:0]         handle;
      logic [15:0]         id;
      logic [4:0]          count;
   } queue_rsp_type;

   typedef struct {
      rqd_pkg::opcode_type op;
      logic [15:0]         handle;
      logic [15:0]         tid;
      bit                  typed;
      queue_rsp_type       rsp;
   } queue_req_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // handle[15:0], thread_id[31:16]
   logic [1:0]  req_tuser;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // found_handle[15:0], found_id[31:16], count[36:32]
   logic [1:0]  rsp_tuser;   // status[1:0]

   // shadow copy of the queue, oldest first
   logic [15:0]   shadow_handles[$];
   logic [15:0]   shadow_ids[$];
   queue_rsp_type pending_rsp[$];
   queue_req_type directed_rows[$];
   logic [15:0]   handle_pool[24];
   logic [15:0]   tid_pool[6];
   int            error_count = 0;
   int            rsp_seen = 0;
   bit            steady_send = 0;

   ready_queue_with_dedup_remove u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic queue_rsp_type predict_queue_op(rqd_pkg::opcode_type op,
                                                      logic [15:0] h, logic [15:0] t);
      queue_rsp_type r;
      int            slot;
      r.status = rqd_pkg::ST_NONE;
      r.handle = '0;
      r.id     = '0;
      slot     = -1;
      case (op)
         rqd_pkg::OP_PUT: begin
            for (int i = 0; i < shadow_handles.size(); i++)
               if (shadow_handles[i] == h) slot = i;
            if (slot >= 0) begin
               r.status = rqd_pkg::ST_DUP;
            end else if (shadow_handles.size() >= QUEUE_DEPTH) begin
               r.status = rqd_pkg::ST_FULL;
            end else begin
               shadow_handles.push_back(h);
               shadow_ids.push_back(t);
               r.status = rqd_pkg::ST_OK;
            end
         end
         rqd_pkg::OP_GET: begin
            if (shadow_handles.size() > 0) begin
               r.handle = shadow_handles.pop_front();
               r.id     = shadow_ids.pop_front();
               r.status = rqd_pkg::ST_OK;
            end
         end
         rqd_pkg::OP_FIND: begin
            // newest match wins
            for (int i = 0; i < shadow_ids.size(); i++)
               if (shadow_ids[i] == t) begin
                  r.handle = shadow_handles[i];
                  r.id     = shadow_ids[i];
                  r.status = rqd_pkg::ST_OK;
               end
         end
         default: begin
            for (int i = shadow_handles.size() - 1; i >= 0; i--)
               if (shadow_handles[i] == h) slot = i;
            if (slot >= 0) begin
               r.handle = shadow_handles[slot];
               r.id     = shadow_ids[slot];
               shadow_handles.delete(slot);
               shadow_ids.delete(slot);
               r.status = rqd_pkg::ST_OK;
            end
         end
      endcase
      r.count = 5'(shadow_handles.size());
      return r;
   endfunction

   function automatic void table_row(rqd_pkg::opcode_type op, logic [15:0] h,
                                     logic [15:0] t, bit typed,
                                     rqd_pkg::status_type st, logic [15:0] fh,
                                     logic [15:0] fi, logic [4:0] cnt);
      queue_req_type row;
      row.op         = op;
      row.handle     = h;
      row.tid        = t;
      row.typed      = typed;
      row.rsp.status = st;
      row.rsp.handle = fh;
      row.rsp.id     = fi;
      row.rsp.count  = cnt;
      directed_rows.push_back(row);
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic queue_req_type random_req(int mode);
      queue_req_type req;
      int            r;
      int            put_lim;
      int            get_lim;
      int            find_lim;
      r = $urandom_range(0, 99);
      case (mode)
         0:       begin put_lim = 65; get_lim = 75; find_lim = 88; end  // fill
         1:       begin put_lim = 20; get_lim = 55; find_lim = 70; end  // drain
         default: begin put_lim = 35; get_lim = 55; find_lim = 75; end
      endcase
      req.typed  = 1'b0;
      req.rsp    = '{rqd_pkg::ST_NONE, '0, '0, '0};
      req.handle = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : handle_pool[$urandom_range(0, 23)];
      req.tid    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : tid_pool[$urandom_range(0, 5)];
      if (r < put_lim) begin
         req.op = rqd_pkg::OP_PUT;
      end else if (r < get_lim) begin
         req.op = rqd_pkg::OP_GET;
      end else if (r < find_lim) begin
         req.op = rqd_pkg::OP_FIND;
         if (shadow_ids.size() > 0 && $urandom_range(0, 9) < 7)
            req.tid = shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
      end else begin
         req.op = rqd_pkg::OP_REMOVE;
         if (shadow_handles.size() > 0 && $urandom_range(0, 3) != 0)
            req.handle = shadow_handles[$urandom_range(0, shadow_handles.size() - 1)];
      end
      return req;
   endfunction

   // entered and left at a falling edge
   task automatic send_req(queue_req_type req);
      int            gap;
      queue_rsp_type predicted;
      gap = steady_send ? 0 : idle_len();
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {req.tid, req.handle};
      req_tuser  <= req.op;
      do
         @(posedge clock);
      while (!req_tready);
      predicted = predict_queue_op(req.op, req.handle, req.tid);
      pending_rsp.push_back(req.typed ? req.rsp : predicted);
      @(negedge clock);
   endtask

   task automatic check_rsp(queue_rsp_type want, queue_rsp_type got);
      if (got.status != want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         error_count++;
      end
      if (got.handle != want.handle) begin
         $error("found_handle: expected %h, actual %h", want.handle, got.handle);
         error_count++;
      end
      if (got.id != want.id) begin
         $error("found_id: expected %h, actual %h", want.id, got.id);
         error_count++;
      end
      if (got.count != want.count) begin
         $error("count: expected %0d, actual %0d", want.count, got.count);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rqd_pkg::status_type'(rsp_tuser);
         got.handle = rsp_tdata[15:0];
         got.id     = rsp_tdata[31:16];
         got.count  = rsp_tdata[36:32];
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected item: status %0d handle %h id %h count %0d",
                   got.status, got.handle, got.id, got.count);
            error_count++;
         end else begin
            check_rsp(pending_rsp.pop_front(), got);
         end
      end
   end

   // receiver: random stalls, steady stretches and two long hold-offs
   initial begin
      int gap_left;
      int hold_left;
      int holds_done;
      int cycle;
      gap_left   = 0;
      hold_left  = 0;
      holds_done = 0;
      cycle      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (hold_left == 0 && ((holds_done == 0 && rsp_seen >= 30) ||
                                (holds_done == 1 && rsp_seen >= 300))) begin
            hold_left = 250;
            holds_done++;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_tready <= 1'b0;
            gap_left--;
         end else begin
            rsp_tready <= 1'b1;
            // no stalls in one stretch out of every four of the cycle count
            if ((cycle / 200) % 4 != 3) gap_left = idle_len();
         end
      end
   end

   initial begin
      int mode;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rqd_pkg::OP_PUT;
      foreach (handle_pool[i]) handle_pool[i] = 16'($urandom);
      foreach (tid_pool[i]) tid_pool[i] = 16'($urandom);
      handle_pool[0] = 16'hFFFF;
      handle_pool[1] = 16'h0000;
      tid_pool[0]    = 16'hFFFF;
      tid_pool[1]    = 16'h0000;

      // empty queue, extremes, duplicate, misses, fill to full, middle removal
      table_row(rqd_pkg::OP_GET,    16'h0000, 16'h0000, 1,
                rqd_pkg::ST_NONE, 16'h0000, 16'h0000, 0);
      table_row(rqd_pkg::OP_FIND,   16'h0000, 16'hFFFF, 1,
                rqd_pkg::ST_NONE, 16'h0000, 16'h0000, 0);
      table_row(rqd_pkg::OP_REMOVE, 16'hFFFF, 16'h0000, 1,
                rqd_pkg::ST_NONE, 16'h0000, 16'h0000, 0);
      table_row(rqd_pkg::OP_PUT,    16'h0000, 16'h0000, 1,
                rqd_pkg::ST_OK,   16'h0000, 16'h0000, 1);
      table_row(rqd_pkg::OP_PUT,    16'hFFFF, 16'hFFFF, 1,
                rqd_pkg::ST_OK,   16'h0000, 16'h0000, 2);
      table_row(rqd_pkg::OP_PUT,    16'hFFFF, 16'h1234, 1,
                rqd_pkg::ST_DUP,  16'h0000, 16'h0000, 2);
      table_row(rqd_pkg::OP_FIND,   16'h0000, 16'hFFFF, 1,
                rqd_pkg::ST_OK,   16'hFFFF, 16'hFFFF, 2);
      table_row(rqd_pkg::OP_FIND,   16'h0000, 16'h0001, 1,
                rqd_pkg::ST_NONE, 16'h0000, 16'h0000, 2);
      table_row(rqd_pkg::OP_REMOVE, 16'h8000, 16'h0000, 1,
                rqd_pkg::ST_NONE, 16'h0000, 16'h0000, 2);
      for (int i = 1; i <= 14; i++)
         table_row(rqd_pkg::OP_PUT, 16'(i), 16'h0F0F ^ 16'(i % 4), 0,
                   rqd_pkg::ST_OK, '0, '0, '0);
      table_row(rqd_pkg::OP_PUT,    16'h7777, 16'h0000, 1,
                rqd_pkg::ST_FULL, 16'h0000, 16'h0000, 16);
      table_row(rqd_pkg::OP_PUT,    16'h0000, 16'h0000, 1,
                rqd_pkg::ST_DUP,  16'h0000, 16'h0000, 16);
      table_row(rqd_pkg::OP_FIND,   16'h0000, 16'h0F0E, 0,
                rqd_pkg::ST_OK,   '0, '0, '0);
      table_row(rqd_pkg::OP_REMOVE, 16'hFFFF, 16'h0000, 1,
                rqd_pkg::ST_OK,   16'hFFFF, 16'hFFFF, 15);
      table_row(rqd_pkg::OP_GET,    16'h0000, 16'h0000, 1,
                rqd_pkg::ST_OK,   16'h0000, 16'h0000, 14);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_req(directed_rows[i]);

      mode = 2;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            mode        = $urandom_range(0, 2);
            steady_send = ($urandom_range(0, 3) == 0);
         end
         send_req(random_req(mode));
      end
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
